// File: rtl/ucer_pkg.sv
// Package for the control endpoint responder: action codes, event codes,
// request codes and the descriptor ROM contents. No dependencies.
package ucer_pkg;

  localparam logic [1:0] EvSetup    = 2'd0;
  localparam logic [1:0] EvOther    = 2'd1;
  localparam logic [1:0] EvBusReset = 2'd2;
  localparam logic [1:0] EvInDone   = 2'd3;

  localparam logic [2:0] ActData  = 3'd0;
  localparam logic [2:0] ActAck   = 3'd1;
  localparam logic [2:0] ActStall = 3'd2;
  localparam logic [2:0] ActEmpty = 3'd3;
  localparam logic [2:0] ActAddr  = 3'd4;
  localparam logic [2:0] ActRxAck = 3'd5;

  localparam logic [7:0] ReqSetAddress = 8'h05;
  localparam logic [7:0] ReqGetDesc    = 8'h06;
  localparam logic [7:0] ReqSetConfig  = 8'h09;
  localparam logic [7:0] ReqGetItf     = 8'h0A;
  localparam logic [7:0] ReqSetItf     = 8'h0B;

  localparam logic [7:0] DescDevice = 8'h01;
  localparam logic [7:0] DescConfig = 8'h02;
  localparam logic [7:0] DescString = 8'h03;
  localparam logic [7:0] DescQual   = 8'h06;

  localparam logic [8:0] OfsDevice = 9'd0;
  localparam logic [8:0] LenDevice = 9'd18;
  localparam logic [8:0] OfsConfig = 9'd18;
  localparam logic [8:0] LenConfig = 9'd190;
  localparam logic [8:0] OfsQual   = 9'd208;
  localparam logic [8:0] LenQual   = 9'd10;
  localparam int RomUsed    = 272;
  localparam int RomStrings = 4;

  // work item handed from front to back
  typedef struct packed {
    logic       is_xfer;   // start a transfer
    logic       is_next;   // in-complete: send next packet or apply address
    logic [2:0] action;    // single result otherwise
    logic [7:0] byte_val;
    logic [6:0] addr;
    logic       cfg;
    logic [8:0] ofs;
    logic [8:0] len;
    logic       zeros;
  } job_t;

  function automatic logic [8:0] str_ofs(input logic [1:0] i);
    case (i)
      2'd0: str_ofs = 9'd218;
      2'd1: str_ofs = 9'd222;
      2'd2: str_ofs = 9'd242;
      default: str_ofs = 9'd262;
    endcase
  endfunction

  function automatic logic [8:0] str_len(input logic [1:0] i);
    case (i)
      2'd0: str_len = 9'd4;
      2'd1: str_len = 9'd20;
      2'd2: str_len = 9'd20;
      default: str_len = 9'd10;
    endcase
  endfunction

  localparam logic [7:0] Rom [RomUsed] = '{
    8'd18, 8'd1, 8'h10, 8'h01, 8'h00, 8'h00, 8'h00, 8'd64, 8'h1C, 8'h1C, 8'h10, 8'h00,
    8'h00, 8'h02, 8'd1, 8'd2, 8'd3, 8'd1,
    8'd9, 8'd2, 8'd190, 8'd0, 8'd3, 8'd1, 8'd0, 8'h80, 8'd50,
    8'd9, 8'd4, 8'd0, 8'd0, 8'd0, 8'h01, 8'h01, 8'h00, 8'd0,
    8'd10, 8'h24, 8'h01, 8'h00, 8'h01, 8'h48, 8'h00, 8'h02, 8'h01, 8'h02,
    8'd12, 8'h24, 8'h02, 8'h01, 8'h01, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'd10, 8'h24, 8'h06, 8'h02, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'd9, 8'h24, 8'h03, 8'h03, 8'h01, 8'h03, 8'h00, 8'h02, 8'h00,
    8'd12, 8'h24, 8'h02, 8'h04, 8'h02, 8'h01, 8'h00, 8'h02, 8'h03, 8'h00, 8'h00, 8'h00,
    8'd10, 8'h24, 8'h06, 8'h05, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'd9, 8'h24, 8'h03, 8'h06, 8'h01, 8'h01, 8'h00, 8'h05, 8'h00,
    8'd9, 8'd4, 8'd1, 8'd0, 8'd0, 8'h01, 8'h02, 8'h00, 8'd0,
    8'd9, 8'd4, 8'd1, 8'd1, 8'd1, 8'h01, 8'h02, 8'h00, 8'd0,
    8'd7, 8'h24, 8'h01, 8'h01, 8'h01, 8'h01, 8'h00,
    8'd11, 8'h24, 8'h02, 8'h01, 8'h02, 8'h02, 8'd16, 8'd1, 8'h80, 8'hBB, 8'h00,
    8'd7, 8'd5, 8'h02, 8'd1, 8'd192, 8'd0, 8'd1,
    8'd7, 8'h25, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00,
    8'd9, 8'd4, 8'd2, 8'd0, 8'd0, 8'h01, 8'h02, 8'h00, 8'd0,
    8'd9, 8'd4, 8'd2, 8'd1, 8'd1, 8'h01, 8'h02, 8'h00, 8'd0,
    8'd7, 8'h24, 8'h01, 8'h06, 8'h01, 8'h01, 8'h00,
    8'd11, 8'h24, 8'h02, 8'h01, 8'h02, 8'h02, 8'd16, 8'd1, 8'h80, 8'hBB, 8'h00,
    8'd7, 8'd5, 8'h81, 8'd1, 8'd192, 8'd0, 8'd1,
    8'd7, 8'h25, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00,
    8'd10, 8'd6, 8'h00, 8'h02, 8'h02, 8'h00, 8'h00, 8'd64, 8'd1, 8'd0,
    8'd4, 8'd3, 8'h09, 8'h04,
    8'd20, 8'd3, 8'h46, 8'd0, 8'h72, 8'd0, 8'h65, 8'd0, 8'h65, 8'd0, 8'h74, 8'd0,
    8'h72, 8'd0, 8'h69, 8'd0, 8'h62, 8'd0, 8'h65, 8'd0,
    8'd20, 8'd3, 8'h46, 8'd0, 8'h54, 8'd0, 8'h42, 8'd0, 8'h20, 8'd0, 8'h41, 8'd0,
    8'h75, 8'd0, 8'h64, 8'd0, 8'h69, 8'd0, 8'h6F, 8'd0,
    8'd10, 8'd3, 8'h31, 8'd0, 8'h32, 8'd0, 8'h33, 8'd0, 8'h34, 8'd0
  };

endpackage

// File: rtl/ucer_front.sv
// Front end: decodes events and setup requests into jobs, keeps address,
// configured flag and alternate settings. Depends on ucer_pkg.
module ucer_front #(
  parameter int InterfaceCount = 3,
  parameter int StringCount    = 4,
  parameter int ZeroReplyBytes = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic [1:0]          event_kind_i,
  input  logic [7:0]          request_type_i,
  input  logic [7:0]          request_code_i,
  input  logic [15:0]         value_word_i,
  input  logic [15:0]         index_word_i,
  input  logic [15:0]         length_word_i,
  input  logic                xfer_more_i,
  output logic                job_valid_o,
  output ucer_pkg::job_t      job_o
);

  localparam int ItfW = (InterfaceCount > 1) ? $clog2(InterfaceCount) : 1;

  logic [7:0] alt_q [InterfaceCount];
  logic [6:0] addr_q;
  logic       pend_q, cfg_q;
  ucer_pkg::job_t job;
  logic       emit, set_alt, set_addr, clr_addr, set_cfg, clr_cfg;
  logic [8:0] want;
  logic       itf_ok;
  logic [ItfW-1:0] itf_idx;
  logic [1:0] sidx;

  assign itf_ok  = {8'd0, index_word_i[7:0]} < 16'(InterfaceCount);
  assign itf_idx = index_word_i[ItfW-1:0];
  assign want    = (length_word_i > 16'd511) ? 9'd511 : length_word_i[8:0];
  assign sidx    = value_word_i[1:0];

  always_comb begin
    job      = '0;
    emit     = 1'b0;
    set_alt  = 1'b0;
    set_addr = 1'b0;
    clr_addr = 1'b0;
    set_cfg  = 1'b0;
    clr_cfg  = 1'b0;
    unique case (event_kind_i)
      ucer_pkg::EvSetup: begin
        if (request_type_i[6:5] == 2'd0) begin
          emit       = 1'b1;
          job.action = ucer_pkg::ActStall;
          unique case (request_code_i)
            ucer_pkg::ReqGetDesc: begin
              if (value_word_i[15:8] == ucer_pkg::DescDevice) begin
                job.is_xfer = 1'b1;
                job.ofs = ucer_pkg::OfsDevice;
                job.len = ucer_pkg::LenDevice;
              end else if (value_word_i[15:8] == ucer_pkg::DescConfig) begin
                job.is_xfer = 1'b1;
                job.ofs = ucer_pkg::OfsConfig;
                job.len = ucer_pkg::LenConfig;
              end else if (value_word_i[15:8] == ucer_pkg::DescQual) begin
                job.is_xfer = 1'b1;
                job.ofs = ucer_pkg::OfsQual;
                job.len = ucer_pkg::LenQual;
              end else if (value_word_i[15:8] == ucer_pkg::DescString &&
                           {8'd0, value_word_i[7:0]} < 16'(StringCount) &&
                           {8'd0, value_word_i[7:0]} < 16'(ucer_pkg::RomStrings)) begin
                job.is_xfer = 1'b1;
                job.ofs = ucer_pkg::str_ofs(sidx);
                job.len = ucer_pkg::str_len(sidx);
              end
            end
            ucer_pkg::ReqSetAddress: begin
              set_addr   = 1'b1;
              job.action = ucer_pkg::ActAck;
            end
            ucer_pkg::ReqGetItf: begin
              job.action   = ucer_pkg::ActData;
              job.byte_val = itf_ok ? alt_q[itf_idx] : 8'd0;
            end
            ucer_pkg::ReqSetItf: begin
              if (itf_ok) begin
                set_alt    = 1'b1;
                job.action = ucer_pkg::ActAck;
              end
            end
            ucer_pkg::ReqSetConfig: begin
              set_cfg    = 1'b1;
              job.action = ucer_pkg::ActAck;
            end
            default: ;
          endcase
        end else if (request_type_i[6:5] == 2'd1) begin
          emit = 1'b1;
          if (length_word_i != 16'd0 && request_type_i[7]) begin
            job.is_xfer = 1'b1;
            job.zeros   = 1'b1;
            job.len     = 9'(ZeroReplyBytes);
          end else begin
            job.action = ucer_pkg::ActAck;
          end
        end
      end
      ucer_pkg::EvOther: begin
        emit       = 1'b1;
        job.action = ucer_pkg::ActRxAck;
      end
      ucer_pkg::EvBusReset: begin
        emit       = 1'b1;
        clr_addr   = 1'b1;
        clr_cfg    = 1'b1;
        job.action = ucer_pkg::ActAddr;
      end
      default: begin
        emit        = 1'b1;
        job.is_next = 1'b1;
        job.addr    = addr_q;
        job.action  = pend_q ? ucer_pkg::ActAddr : ucer_pkg::ActData;
        clr_addr    = 1'b0;
      end
    endcase
    if (job.is_xfer && job.len > want) job.len = want;
    job.cfg = (cfg_q | set_cfg) & ~clr_cfg;
  end

  // the back end is idle whenever a word is accepted, so its byte count is settled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q      <= '0;
      pend_q      <= 1'b0;
      cfg_q       <= 1'b0;
      job_valid_o <= 1'b0;
      for (int i = 0; i < InterfaceCount; i++) alt_q[i] <= '0;
    end else begin
      job_valid_o <= valid_i & emit;
      if (valid_i) begin
        job_o <= job;
        if (set_addr) begin
          addr_q <= value_word_i[6:0];
          pend_q <= 1'b1;
        end
        if (clr_addr) begin
          addr_q <= '0;
          pend_q <= 1'b0;
        end
        if (job.is_next && !xfer_more_i) pend_q <= 1'b0;
        if (set_cfg) cfg_q <= 1'b1;
        if (clr_cfg) cfg_q <= 1'b0;
        if (set_alt) alt_q[itf_idx] <= value_word_i[7:0];
      end
    end
  end

endmodule

// File: rtl/ucer_back.sv
// Back end: turns jobs into result words, streaming descriptor bytes from
// the ROM, or zero bytes, one per cycle. Depends on ucer_pkg.
module ucer_back #(
  parameter int PacketBytes = 64,
  parameter int RomDepth    = 512
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           job_valid_i,
  input  ucer_pkg::job_t job_i,
  output logic           busy_o,
  output logic           more_o,
  output logic           strobe_o,
  output logic [2:0]     action_o,
  output logic [7:0]     data_byte_o,
  output logic           packet_end_o,
  output logic           final_packet_o,
  output logic [6:0]     device_address_o,
  output logic           configured_o
);

  localparam int CntW = $clog2(PacketBytes + 1);

  logic [8:0]      ptr_q, ptr_d, rem_q;
  logic            zeros_q, fin_q, cfg_q;
  logic [CntW-1:0] cnt_q;
  logic            run_q;
  logic [8:0]      n;
  logic [8:0]      rem_now;
  logic [7:0]      rom_q;

  assign busy_o = run_q;
  assign more_o = rem_q != 9'd0;

  // rom_q holds the ROM byte at ptr_q (zero past RomUsed or RomDepth), except straight after reset
  always_comb begin
    ptr_d = ptr_q;
    if (run_q) ptr_d = ptr_q + 9'd1;
    else if (job_valid_i && job_i.is_xfer) ptr_d = job_i.ofs;
  end

  assign rem_now = job_i.is_xfer ? job_i.len : rem_q;
  assign n = (rem_now > 9'(PacketBytes)) ? 9'(PacketBytes) : rem_now;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q    <= '0;
      rom_q    <= '0;
      rem_q    <= '0;
      zeros_q  <= 1'b0;
      fin_q    <= 1'b0;
      cfg_q    <= 1'b0;
      cnt_q    <= '0;
      run_q    <= 1'b0;
      strobe_o <= 1'b0;
    end else begin
      strobe_o <= 1'b0;
      ptr_q    <= ptr_d;
      rom_q    <= (32'(ptr_d) < ucer_pkg::RomUsed && 32'(ptr_d) < RomDepth) ?
                  ucer_pkg::Rom[ptr_d] : 8'd0;
      if (run_q) begin
        strobe_o         <= 1'b1;
        action_o         <= ucer_pkg::ActData;
        data_byte_o      <= zeros_q ? 8'd0 : rom_q;
        final_packet_o   <= fin_q;
        device_address_o <= '0;
        configured_o     <= cfg_q;
        packet_end_o     <= cnt_q == CntW'(1);
        cnt_q            <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) run_q <= 1'b0;
      end else if (job_valid_i) begin
        cfg_q            <= job_i.cfg;
        configured_o     <= job_i.cfg;
        device_address_o <= '0;
        data_byte_o      <= '0;
        final_packet_o   <= 1'b0;
        packet_end_o     <= 1'b1;
        if (job_i.is_xfer || (job_i.is_next && rem_q != 9'd0)) begin
          if (job_i.is_xfer) begin
            zeros_q <= job_i.zeros;
          end
          if (n == 9'd0) begin
            strobe_o       <= 1'b1;
            action_o       <= ucer_pkg::ActEmpty;
            final_packet_o <= 1'b1;
            rem_q          <= '0;
          end else begin
            fin_q <= (rem_now == n);
            rem_q <= rem_now - n;
            cnt_q <= CntW'(n);
            run_q <= 1'b1;
          end
        end else if (job_i.is_next) begin
          if (job_i.action == ucer_pkg::ActAddr) begin
            strobe_o         <= 1'b1;
            action_o         <= ucer_pkg::ActAddr;
            device_address_o <= job_i.addr;
          end
        end else begin
          strobe_o    <= 1'b1;
          action_o    <= job_i.action;
          data_byte_o <= job_i.byte_val;
          if (job_i.action == ucer_pkg::ActData) begin
            final_packet_o <= 1'b1;
            rem_q          <= '0;
          end
        end
      end
    end
  end

endmodule

// File: rtl/usb_control_endpoint_responder.sv
// Top level of the USB control endpoint responder; ties the request decoder
// to the result sequencer. Depends on ucer_pkg, ucer_front, ucer_back.
//
// Each accepted event is decoded and registered as one job (a setup request
// whose type field is neither 0 nor 1 gives none); the sequencer then
// sends its results one per clock with result_valid_o, which the receiver
// cannot stall. A new event is accepted only once the previous one is
// done. A data packet holds at most PacketBytes bytes; its first byte
// passes the job register and the registered ROM read first. busy is high
// while a job is queued or a packet is streaming.
module usb_control_endpoint_responder #(
  parameter int PacketBytes        = 64,
  parameter int InterfaceCount     = 3,
  parameter int StringCount        = 4,
  parameter int ZeroReplyBytes     = 64,
  parameter int DescriptorRomDepth = 512
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  event_kind_i,
  input  logic [7:0]  request_type_i,
  input  logic [7:0]  request_code_i,
  input  logic [15:0] value_word_i,
  input  logic [15:0] index_word_i,
  input  logic [15:0] length_word_i,
  output logic        result_valid_o,
  output logic [2:0]  action_o,
  output logic [7:0]  data_byte_o,
  output logic        packet_end_o,
  output logic        final_packet_o,
  output logic [6:0]  device_address_o,
  output logic        configured_o
);

  logic           job_valid, back_busy, xfer_more;
  ucer_pkg::job_t job;

  assign busy = back_busy | job_valid;

  ucer_front #(
    .InterfaceCount(InterfaceCount),
    .StringCount   (StringCount),
    .ZeroReplyBytes(ZeroReplyBytes)
  ) u_front (
    .clk_i, .rst_ni,
    .valid_i       (start & ~busy),
    .event_kind_i, .request_type_i, .request_code_i,
    .value_word_i, .index_word_i, .length_word_i,
    .xfer_more_i   (xfer_more),
    .job_valid_o   (job_valid),
    .job_o         (job)
  );

  ucer_back #(
    .PacketBytes(PacketBytes),
    .RomDepth   (DescriptorRomDepth)
  ) u_back (
    .clk_i, .rst_ni,
    .job_valid_i   (job_valid),
    .job_i         (job),
    .busy_o        (back_busy),
    .more_o        (xfer_more),
    .strobe_o      (result_valid_o),
    .action_o, .data_byte_o, .packet_end_o, .final_packet_o,
    .device_address_o, .configured_o
  );

endmodule
